@@ hdl/touch_coordinate_conditioner_top_assert.svh @@
// ----------------------------------------------------------------------------
// Touch coordinate conditioner assertion macros
// Shared concurrent-check shorthands, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TOUCH_COORDINATE_CONDITIONER_TOP_ASSERT_SVH
`define TOUCH_COORDINATE_CONDITIONER_TOP_ASSERT_SVH

// same-cycle implication
`define TCC_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("touch conditioner check failed");

// next-cycle implication
`define TCC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("touch conditioner check failed");

`endif

@@ hdl/tcc_pkg.sv @@
// ----------------------------------------------------------------------------
// tcc_pkg
// Widths, register map, reset values and shared types of the touch
// coordinate conditioner.
// ----------------------------------------------------------------------------
package tcc_pkg;

   // field widths
   localparam int RAW_W  = 16;
   localparam int SCR_W  = 12;
   localparam int PROD_W = RAW_W + SCR_W;
   localparam int STEP_W = $clog2(SCR_W);
   localparam int IDX_W  = 3;

   // sample pairs averaged per request (the word carries two)
   localparam int MAX_SAMPLES  = 2;
   localparam int SAMPLE_LIMIT = (MAX_SAMPLES < 2) ? MAX_SAMPLES : 2;

   // action codes
   localparam logic ACT_TICK    = 1'b0;
   localparam logic ACT_REQUEST = 1'b1;

   // register map
   typedef enum logic [IDX_W-1:0] {
      CSR_HOLDOFF  = 3'd0,
      CSR_MIN_X    = 3'd1,
      CSR_MAX_X    = 3'd2,
      CSR_MIN_Y    = 3'd3,
      CSR_MAX_Y    = 3'd4,
      CSR_SCREEN_W = 3'd5,
      CSR_SCREEN_H = 3'd6
   } csr_index_type;

   // register reset values
   localparam logic [RAW_W-1:0] HOLDOFF_RST  = 16'd200;
   localparam logic [RAW_W-1:0] MIN_RAW_RST  = 16'd0;
   localparam logic [RAW_W-1:0] MAX_RAW_RST  = 16'hFFFF;
   localparam logic [SCR_W-1:0] SCREEN_W_RST = 12'd320;
   localparam logic [SCR_W-1:0] SCREEN_H_RST = 12'd240;

   // axis unit sequencer
   typedef enum logic [2:0] {
      AX_IDLE,
      AX_CLAMP,
      AX_DIFF,
      AX_MUL,
      AX_DIV,
      AX_DONE
   } axis_state_type;

   // top-level control
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_HOLD
   } ctrl_state_type;

   // axis unit status
   typedef struct packed {
      logic busy;
      logic done;
   } axis_stat_type;

endpackage

@@ hdl/touch_coordinate_conditioner_top.sv @@
// ----------------------------------------------------------------------------
// touch_coordinate_conditioner_top
// Holdoff timer, sample averaging, register file and result register around
// two serial axis units.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one word per millisecond tick (req_action = 0) or per
//   coordinate request (req_action = 1) carrying two raw X/Y pairs with
//   pen-down flags. Ticks produce no response word; each request produces one.
//   rsp_ channel: accepted flag, samples used, screen X and inverted screen Y.
//   csr_ channel: register writes, always ready; write only while no word is
//   in flight.
// Timing:
//   A tick is absorbed in the idle state; a refused request goes through the
//   hold state to the response register. A served request passes clamp and
//   difference, a bit-serial multiply over the 12 span bits, a restoring
//   divide producing 12 quotient bits, and hand-off via the hold state. The
//   next word is taken once the response is registered.
// Reset:
//   Synchronous, active high; registers return to their defaults and the
//   millisecond count starts at zero.
// Stall:
//   A response waits in the output register; a second result waits in the
//   control stage and no further word is taken until the first one leaves.
// ----------------------------------------------------------------------------
module touch_coordinate_conditioner_top (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic                          req_pen_down_first,
   input  logic                          req_pen_down_second,
   input  logic [tcc_pkg::RAW_W-1:0]     req_raw_x_first,
   input  logic [tcc_pkg::RAW_W-1:0]     req_raw_y_first,
   input  logic [tcc_pkg::RAW_W-1:0]     req_raw_x_second,
   input  logic [tcc_pkg::RAW_W-1:0]     req_raw_y_second,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_accepted,
   output logic [1:0]                    rsp_samples_used,
   output logic [tcc_pkg::SCR_W-1:0]     rsp_screen_x,
   output logic [tcc_pkg::SCR_W-1:0]     rsp_screen_y,
   // register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tcc_pkg::IDX_W-1:0]     csr_index,
   input  logic [tcc_pkg::RAW_W-1:0]     csr_wdata
);
   import tcc_pkg::*;

   ctrl_state_type    state_ff, state_in;

   // configuration registers
   logic [RAW_W-1:0]  holdoff_ff, min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic [SCR_W-1:0]  screen_w_ff, screen_h_ff;

   logic [RAW_W-1:0]  elapsed_ff, elapsed_in;

   // pending result
   logic              pend_acc_ff, pend_acc_in;
   logic [1:0]        pend_n_ff, pend_n_in;
   logic [SCR_W-1:0]  pend_x_ff, pend_x_in;
   logic [SCR_W-1:0]  pend_y_ff, pend_y_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_acc_ff, rsp_acc_in;
   logic [1:0]        rsp_n_ff, rsp_n_in;
   logic [SCR_W-1:0]  rsp_x_ff, rsp_x_in;
   logic [SCR_W-1:0]  rsp_y_ff, rsp_y_in;

   logic              req_fire;
   logic              axis_start;
   logic              use_second;
   logic [1:0]        n_cnt;
   logic [RAW_W:0]    sum_x, sum_y;
   logic [RAW_W-1:0]  avg_x, avg_y;
   axis_stat_type     x_stat, y_stat;
   logic [SCR_W-1:0]  x_result, y_result;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         holdoff_ff  <= HOLDOFF_RST;
         min_x_ff    <= MIN_RAW_RST;
         max_x_ff    <= MAX_RAW_RST;
         min_y_ff    <= MIN_RAW_RST;
         max_y_ff    <= MAX_RAW_RST;
         screen_w_ff <= SCREEN_W_RST;
         screen_h_ff <= SCREEN_H_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HOLDOFF:  holdoff_ff  <= csr_wdata;
            CSR_MIN_X:    min_x_ff    <= csr_wdata;
            CSR_MAX_X:    max_x_ff    <= csr_wdata;
            CSR_MIN_Y:    min_y_ff    <= csr_wdata;
            CSR_MAX_Y:    max_y_ff    <= csr_wdata;
            CSR_SCREEN_W: screen_w_ff <= csr_wdata[SCR_W-1:0];
            CSR_SCREEN_H: screen_h_ff <= csr_wdata[SCR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // pressed-sample count and floor average (divide by one or two)
   assign use_second = (SAMPLE_LIMIT >= 2) && req_pen_down_first && req_pen_down_second;
   assign n_cnt      = use_second ? 2'd2 : (req_pen_down_first ? 2'd1 : 2'd0);
   assign sum_x      = {1'b0, req_raw_x_first} + {1'b0, req_raw_x_second};
   assign sum_y      = {1'b0, req_raw_y_first} + {1'b0, req_raw_y_second};
   assign avg_x      = use_second ? sum_x[RAW_W:1]
                       : (req_pen_down_first ? req_raw_x_first : '0);
   assign avg_y      = use_second ? sum_y[RAW_W:1]
                       : (req_pen_down_first ? req_raw_y_first : '0);

   // axis units
   tcc_axis_unit u_axis_x (
      .clock  (clock),
      .reset  (reset),
      .start  (axis_start),
      .invert (1'b0),
      .avg    (avg_x),
      .lo     (min_x_ff),
      .hi     (max_x_ff),
      .span   (screen_w_ff),
      .stat   (x_stat),
      .result (x_result)
   );

   tcc_axis_unit u_axis_y (
      .clock  (clock),
      .reset  (reset),
      .start  (axis_start),
      .invert (1'b1),
      .avg    (avg_y),
      .lo     (min_y_ff),
      .hi     (max_y_ff),
      .span   (screen_h_ff),
      .stat   (y_stat),
      .result (y_result)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_acc_ff <= pend_acc_in;
      pend_n_ff   <= pend_n_in;
      pend_x_ff   <= pend_x_in;
      pend_y_ff   <= pend_y_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_n_ff    <= rsp_n_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
   end

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      elapsed_in   = elapsed_ff;
      axis_start   = 1'b0;
      pend_acc_in  = pend_acc_ff;
      pend_n_in    = pend_n_ff;
      pend_x_in    = pend_x_ff;
      pend_y_in    = pend_y_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_acc_in   = rsp_acc_ff;
      rsp_n_in     = rsp_n_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_action == ACT_TICK) begin
                  // saturating millisecond count
                  if (elapsed_ff != '1) begin
                     elapsed_in = elapsed_ff + 1'b1;
                  end
               end else if (elapsed_ff < holdoff_ff) begin
                  // refused: count keeps running
                  pend_acc_in = 1'b0;
                  pend_n_in   = 2'd0;
                  pend_x_in   = '0;
                  pend_y_in   = '0;
                  state_in    = ST_HOLD;
               end else begin
                  elapsed_in  = '0;
                  pend_acc_in = 1'b1;
                  pend_n_in   = n_cnt;
                  axis_start  = 1'b1;
                  state_in    = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            if (x_stat.done) begin
               pend_x_in = x_result;
               pend_y_in = y_result;
               state_in  = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // move into the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = pend_acc_ff;
               rsp_n_in     = pend_n_ff;
               rsp_x_in     = pend_x_ff;
               rsp_y_in     = pend_y_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_acc_ff;
   assign rsp_samples_used = rsp_n_ff;
   assign rsp_screen_x     = rsp_x_ff;
   assign rsp_screen_y     = rsp_y_ff;

   // checks
`include "touch_coordinate_conditioner_top_assert.svh"

   `TCC_ASSERT_NOW(a_axes_in_step, 1'b1, x_stat.done == y_stat.done)
   `TCC_ASSERT_NOW(a_calc_busy, state_ff == ST_CALC, x_stat.busy)
   `TCC_ASSERT_NOW(a_refused_zero, rsp_valid_ff && !rsp_acc_ff,
                   rsp_n_ff == 2'd0 && rsp_x_ff == '0 && rsp_y_ff == '0)
   `TCC_ASSERT_NOW(a_samples_limit, rsp_valid_ff, rsp_n_ff <= 2'(SAMPLE_LIMIT))
   `TCC_ASSERT_NEXT(a_served_clears, req_fire && req_action == ACT_REQUEST
                    && elapsed_ff >= holdoff_ff, elapsed_ff == '0)

endmodule

@@ hdl/tcc_axis_unit.sv @@
// ----------------------------------------------------------------------------
// tcc_axis_unit
// One axis: clamp to the raw window, bit-serial multiply by the screen span,
// then restoring division by the window width, one bit per cycle.
// ----------------------------------------------------------------------------
module tcc_axis_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          invert,
   input  logic [tcc_pkg::RAW_W-1:0]     avg,
   input  logic [tcc_pkg::RAW_W-1:0]     lo,
   input  logic [tcc_pkg::RAW_W-1:0]     hi,
   input  logic [tcc_pkg::SCR_W-1:0]     span,
   output tcc_pkg::axis_stat_type        stat,
   output logic [tcc_pkg::SCR_W-1:0]     result
);
   import tcc_pkg::*;

   axis_state_type       state_ff, state_in;
   logic [RAW_W-1:0]     v_ff, v_in;
   logic [RAW_W-1:0]     d_ff, d_in;
   logic [RAW_W-1:0]     den_ff, den_in;
   logic                 empty_ff, empty_in;
   logic [SCR_W-1:0]     span_ff, span_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [STEP_W-1:0]    step_ff, step_in;

   logic                 last_step;
   logic [RAW_W:0]       trial;
   logic                 fits;
   logic [RAW_W:0]       rem_next;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AX_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      d_ff     <= d_in;
      den_ff   <= den_in;
      empty_ff <= empty_in;
      span_ff  <= span_in;
      acc_ff   <= acc_in;
   end

   // one restoring division step: remainder in the top, dividend bits below
   assign last_step = (step_ff == STEP_W'(SCR_W - 1));
   assign trial     = {acc_ff[PROD_W-1:SCR_W], acc_ff[SCR_W-1]};
   assign fits      = (trial >= {1'b0, den_ff});
   assign rem_next  = fits ? (trial - {1'b0, den_ff}) : trial;

   // sequencer and datapath next values
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      v_in     = v_ff;
      d_in     = d_ff;
      den_in   = den_ff;
      empty_in = empty_ff;
      span_in  = span_ff;
      acc_in   = acc_ff;

      unique case (state_ff)
         AX_IDLE: begin
            if (start) begin
               v_in     = avg;
               state_in = AX_CLAMP;
            end
         end
         AX_CLAMP: begin
            // clamp into the window; an empty window forces zero later
            empty_in = (hi <= lo);
            if (v_ff < lo) begin
               v_in = lo;
            end else if (v_ff > hi) begin
               v_in = hi;
            end
            state_in = AX_DIFF;
         end
         AX_DIFF: begin
            d_in     = invert ? (hi - v_ff) : (v_ff - lo);
            den_in   = hi - lo;
            span_in  = span;
            acc_in   = '0;
            step_in  = '0;
            state_in = AX_MUL;
         end
         AX_MUL: begin
            // shift-add, span MSB first
            acc_in  = {acc_ff[PROD_W-2:0], 1'b0}
                      + (span_ff[SCR_W-1] ? {{SCR_W{1'b0}}, d_ff} : '0);
            span_in = {span_ff[SCR_W-2:0], 1'b0};
            if (last_step) begin
               step_in  = '0;
               state_in = AX_DIV;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         AX_DIV: begin
            // quotient bits shift in at the bottom
            acc_in = {rem_next[RAW_W-1:0], acc_ff[SCR_W-2:0], fits};
            if (last_step) begin
               step_in  = '0;
               state_in = AX_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         AX_DONE: begin
            state_in = AX_IDLE;
         end
         default: begin
            state_in = AX_IDLE;
         end
      endcase
   end

   // status and result
   assign stat.busy = (state_ff != AX_IDLE);
   assign stat.done = (state_ff == AX_DONE);
   assign result    = empty_ff ? '0 : acc_ff[SCR_W-1:0];

endmodule

@@ sim/tb_touch_coordinate_conditioner_top.sv @@
// ----------------------------------------------------------------------------
// tb_touch_coordinate_conditioner_top
// Self-checking bench for the touch coordinate conditioner. Words go in on
// the req_ channel with random gaps. A shadow of the registers and of the
// millisecond count predicts each response word. Responses are popped in
// order on the rsp_ channel under random back-pressure and compared field by
// field. Directed tests cover the reset values, sample and window corner
// cases and the holdoff. Random phases follow, each with its own register
// setting.
// ----------------------------------------------------------------------------
module tb_touch_coordinate_conditioner_top;
   import tcc_pkg::*;

   typedef struct packed {
      logic             action;
      logic             pen_first;
      logic             pen_second;
      logic [RAW_W-1:0] x_first;
      logic [RAW_W-1:0] y_first;
      logic [RAW_W-1:0] x_second;
      logic [RAW_W-1:0] y_second;
   } touch_word_type;

   typedef struct packed {
      logic             accepted;
      logic [1:0]       used;
      logic [SCR_W-1:0] screen_x;
      logic [SCR_W-1:0] screen_y;
   } coord_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_action = 1'b0;
   logic             req_pen_down_first = 1'b0;
   logic             req_pen_down_second = 1'b0;
   logic [RAW_W-1:0] req_raw_x_first = '0;
   logic [RAW_W-1:0] req_raw_y_first = '0;
   logic [RAW_W-1:0] req_raw_x_second = '0;
   logic [RAW_W-1:0] req_raw_y_second = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_accepted;
   logic [1:0]       rsp_samples_used;
   logic [SCR_W-1:0] rsp_screen_x;
   logic [SCR_W-1:0] rsp_screen_y;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [RAW_W-1:0] csr_wdata = '0;

   // register shadow and millisecond count
   logic [RAW_W-1:0] holdoff_cfg = HOLDOFF_RST;
   logic [RAW_W-1:0] win_x_lo    = MIN_RAW_RST;
   logic [RAW_W-1:0] win_x_hi    = MAX_RAW_RST;
   logic [RAW_W-1:0] win_y_lo    = MIN_RAW_RST;
   logic [RAW_W-1:0] win_y_hi    = MAX_RAW_RST;
   logic [SCR_W-1:0] span_x      = SCREEN_W_RST;
   logic [SCR_W-1:0] span_y      = SCREEN_H_RST;
   logic [RAW_W-1:0] ms_since_touch = '0;

   coord_type coord_q[$];
   int        err_cnt = 0;
   bit        calm = 1'b0;

   touch_coordinate_conditioner_top i_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // clamp one axis to its raw window and map it onto the screen span
   function automatic logic [SCR_W-1:0] map_to_screen(input logic [RAW_W-1:0] avg,
                                                      input logic [RAW_W-1:0] lo,
                                                      input logic [RAW_W-1:0] hi,
                                                      input logic [SCR_W-1:0] span,
                                                      input bit invert);
      logic [RAW_W-1:0]  v;
      logic [PROD_W-1:0] prod;
      if (hi <= lo) return '0;
      v = (avg < lo) ? lo : (avg > hi) ? hi : avg;
      v = invert ? hi - v : v - lo;
      prod = PROD_W'(v) * PROD_W'(span);
      return SCR_W'(prod / PROD_W'(hi - lo));
   endfunction

   // advance the count on a tick, or queue the coordinates a request yields
   function automatic void serve_word(input touch_word_type w);
      coord_type        c;
      bit               pen [2];
      logic [RAW_W-1:0] rx [2];
      logic [RAW_W-1:0] ry [2];
      logic [RAW_W:0]   sum_x, sum_y;
      logic [RAW_W-1:0] avg_x, avg_y;
      logic [1:0]       n;
      bit               stop;
      c = '0;
      if (w.action == ACT_TICK) begin
         if (ms_since_touch != '1) ms_since_touch++;
         return;
      end
      // refused: count keeps running
      if (ms_since_touch < holdoff_cfg) begin
         coord_q.push_back(c);
         return;
      end
      ms_since_touch = '0;
      pen = '{w.pen_first, w.pen_second};
      rx  = '{w.x_first, w.x_second};
      ry  = '{w.y_first, w.y_second};
      n = '0; sum_x = '0; sum_y = '0; stop = 1'b0;
      // sampling ends at the first pair with the pen up
      for (int i = 0; i < SAMPLE_LIMIT; i++) begin
         if (!pen[i]) stop = 1'b1;
         if (!stop) begin
            n++;
            sum_x += rx[i];
            sum_y += ry[i];
         end
      end
      avg_x = (n != 0) ? RAW_W'(sum_x / n) : '0;
      avg_y = (n != 0) ? RAW_W'(sum_y / n) : '0;
      c.accepted = 1'b1;
      c.used     = n;
      c.screen_x = map_to_screen(avg_x, win_x_lo, win_x_hi, span_x, 1'b0);
      c.screen_y = map_to_screen(avg_y, win_y_lo, win_y_hi, span_y, 1'b1);
      coord_q.push_back(c);
   endfunction

   // response checker and back-pressure
   always @(posedge clock) begin
      coord_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_accepted, rsp_samples_used, rsp_screen_x, rsp_screen_y};
         if (coord_q.size() == 0) begin
            $error("response word with no request pending");
            err_cnt++;
         end else begin
            want = coord_q.pop_front();
            if (got.accepted !== want.accepted) begin
               $error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
               err_cnt++;
            end
            if (got.used !== want.used) begin
               $error("samples_used: expected %0d, actual %0d", want.used, got.used);
               err_cnt++;
            end
            if (got.screen_x !== want.screen_x) begin
               $error("screen_x: expected %0d, actual %0d", want.screen_x, got.screen_x);
               err_cnt++;
            end
            if (got.screen_y !== want.screen_y) begin
               $error("screen_y: expected %0d, actual %0d", want.screen_y, got.screen_y);
               err_cnt++;
            end
         end
      end
      rsp_ready <= calm || ($urandom_range(99) >= 25);
   end

   // send one word; valid stays up across back-to-back words
   task automatic send_word(input touch_word_type w);
      while (!calm && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_action          <= w.action;
      req_pen_down_first  <= w.pen_first;
      req_pen_down_second <= w.pen_second;
      req_raw_x_first     <= w.x_first;
      req_raw_y_first     <= w.y_first;
      req_raw_x_second    <= w.x_second;
      req_raw_y_second    <= w.y_second;
      do @(posedge clock); while (!req_ready);
      serve_word(w);
   endtask

   task automatic send_ticks(input int count);
      touch_word_type w;
      w = '0;
      w.action = ACT_TICK;
      repeat (count) send_word(w);
   endtask

   task automatic send_touch(input bit p1, input bit p2,
                             input logic [RAW_W-1:0] x1, input logic [RAW_W-1:0] y1,
                             input logic [RAW_W-1:0] x2, input logic [RAW_W-1:0] y2);
      send_word('{ACT_REQUEST, p1, p2, x1, y1, x2, y2});
   endtask

   // drain all responses, then let any tick still in flight finish
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (coord_q.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [RAW_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_HOLDOFF:  holdoff_cfg = data;
         CSR_MIN_X:    win_x_lo = data;
         CSR_MAX_X:    win_x_hi = data;
         CSR_MIN_Y:    win_y_lo = data;
         CSR_MAX_Y:    win_y_hi = data;
         CSR_SCREEN_W: span_x = data[SCR_W-1:0];
         CSR_SCREEN_H: span_y = data[SCR_W-1:0];
         default: ;
      endcase
   endtask

   // full register setting; junk in the unused upper bits of the spans
   task automatic program_regs(input logic [RAW_W-1:0] hold,
                               input logic [RAW_W-1:0] lox, input logic [RAW_W-1:0] hix,
                               input logic [RAW_W-1:0] loy, input logic [RAW_W-1:0] hiy,
                               input logic [SCR_W-1:0] wx, input logic [SCR_W-1:0] hy);
      settle();
      write_reg(CSR_HOLDOFF, hold);
      write_reg(CSR_MIN_X, lox);
      write_reg(CSR_MAX_X, hix);
      write_reg(CSR_MIN_Y, loy);
      write_reg(CSR_MAX_Y, hiy);
      write_reg(CSR_SCREEN_W, {4'($urandom), wx});
      write_reg(CSR_SCREEN_H, {4'($urandom), hy});
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // reset values: holdoff of 200 ticks, full window, 320 x 240
   task automatic test_reset_defaults();
      send_touch(1, 1, 16'h1234, 16'h4321, 16'h2222, 16'h3333);
      send_ticks(199);
      send_touch(1, 1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      send_ticks(1);
      send_touch(1, 1, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
      send_touch(1, 0, 16'h0100, 16'h0200, 16'h0300, 16'h0400);
   endtask

   // pen patterns, raw extremes, clamping and degenerate windows
   task automatic test_samples_and_windows();
      program_regs(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 12'd320, 12'd240);
      send_touch(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_touch(0, 1, 16'hABCD, 16'h1234, 16'hFFFF, 16'hFFFF);
      send_touch(1, 0, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
      send_touch(1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF);
      send_touch(1, 1, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
      // narrow window, full X span, no Y span
      program_regs(16'd0, 16'd1000, 16'd3000, 16'd500, 16'd4000, 12'd4095, 12'd0);
      send_touch(1, 1, 16'd10, 16'd20, 16'd30, 16'd40);
      send_touch(1, 0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
      send_touch(1, 1, 16'd1500, 16'd700, 16'd2501, 16'd3999);
      send_touch(1, 1, 16'd1000, 16'd4000, 16'd3000, 16'd500);
      // X window empty, Y window inverted
      program_regs(16'd0, 16'd1234, 16'd1234, 16'd5000, 16'd100, 12'd4095, 12'd4095);
      send_touch(1, 1, 16'd1234, 16'd2000, 16'd1234, 16'd3000);
      send_touch(0, 0, 16'd0, 16'd0, 16'd0, 16'd0);
   endtask

   // refused requests leave the count running
   task automatic test_holdoff();
      program_regs(16'd3, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 12'd4095, 12'd4095);
      send_touch(1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_ticks(2);
      send_touch(1, 0, 16'h5555, 16'hAAAA, 16'h0, 16'h0);
      send_ticks(1);
      send_touch(1, 0, 16'h5555, 16'hAAAA, 16'h0, 16'h0);
      send_touch(1, 1, 16'h1111, 16'h2222, 16'h3333, 16'h4444);
   endtask

   function automatic logic [RAW_W-1:0] pick_raw(input logic [RAW_W-1:0] lo,
                                                 input logic [RAW_W-1:0] hi);
      int unsigned a, b;
      a = (lo > 300) ? lo - 300 : 0;
      b = (hi < 65235) ? hi + 300 : 65535;
      if ($urandom_range(3) == 0) return RAW_W'($urandom);
      return RAW_W'($urandom_range(a, b));
   endfunction

   // random phases, each under its own register setting
   task automatic test_random_traffic();
      logic [RAW_W-1:0] hold, lox, hix, loy, hiy;
      logic [SCR_W-1:0] wx, hy;
      int               tick_pct;
      touch_word_type   w;
      for (int ph = 0; ph < 11; ph++) begin
         hold = RAW_W'($urandom_range(0, 2));
         tick_pct = 30;
         if (ph == 3) hold = '1;
         if (ph == 5) begin
            hold = RAW_W'($urandom_range(5, 15));
            tick_pct = 70;
         end
         lox = RAW_W'($urandom_range(0, 40000));
         hix = RAW_W'(lox + $urandom_range(1, 65535 - lox));
         loy = RAW_W'($urandom_range(0, 40000));
         hiy = RAW_W'(loy + $urandom_range(1, 65535 - loy));
         if (ph == 0) begin
            lox = '0; hix = '1; loy = '0; hiy = '1;
         end
         if (ph == 2) begin
            hix = lox;
            hiy = RAW_W'($urandom_range(0, loy));
         end
         wx = SCR_W'($urandom);
         hy = SCR_W'($urandom);
         if (ph == 4) begin
            wx = '1; hy = '1;
         end
         if (ph == 6) begin
            wx = '0; hy = '0;
         end
         program_regs(hold, lox, hix, loy, hiy, wx, hy);
         calm = (ph == 0);
         repeat (30) begin
            w.action     = ($urandom_range(99) < tick_pct) ? ACT_TICK : ACT_REQUEST;
            w.pen_first  = ($urandom_range(99) < 80);
            w.pen_second = ($urandom_range(99) < 70);
            w.x_first    = pick_raw(win_x_lo, win_x_hi);
            w.y_first    = pick_raw(win_y_lo, win_y_hi);
            w.x_second   = pick_raw(win_x_lo, win_x_hi);
            w.y_second   = pick_raw(win_y_lo, win_y_hi);
            send_word(w);
         end
         calm = 1'b0;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_samples_and_windows();
      test_holdoff();
      test_random_traffic();
      settle();
      if (err_cnt == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ touch_coordinate_conditioner_top.f @@
+incdir+hdl
hdl/tcc_pkg.sv
hdl/tcc_axis_unit.sv
hdl/touch_coordinate_conditioner_top.sv
sim/tb_touch_coordinate_conditioner_top.sv
